// File: rtl/core/omx_pkg.sv
package omx_pkg;

  localparam int unsigned PREFIX_LEN = 5;
  localparam int unsigned PREFIX_COUNT = 3;

  localparam logic [7:0] CHAR_PIPE = 8'h7C;
  localparam logic [7:0] CHAR_NL = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_PLUS = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [35:0] MAG_CAP = 36'h0_8000_0000;

  typedef enum logic [1:0] {
    AXIS_NONE = 2'd0,
    AXIS_X    = 2'd1,
    AXIS_Y    = 2'd2,
    AXIS_Z    = 2'd3
  } axis_code_t;

  typedef struct packed {
    logic        fire;
    axis_code_t  axis;
    logic [15:0] value;
  } omx_event_t;

  // prefixes: 0 "L3_x:", 1 "L3_y:", 2 "R3_x:"
  function automatic logic [7:0] prefix_char(input logic [1:0] k, input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0: ch = (k == 2'd2) ? 8'h52 : 8'h4C;
      3'd1: ch = 8'h33;
      3'd2: ch = 8'h5F;
      3'd3: ch = (k == 2'd1) ? 8'h79 : 8'h78;
      3'd4: ch = 8'h3A;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// File: rtl/core/omx_parse.sv
module omx_parse import omx_pkg::*; #(
  parameter int unsigned MESSAGE_CAPACITY = 20
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output omx_event_t ev
);

  localparam int unsigned CW = $clog2(MESSAGE_CAPACITY);

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  logic [CW-1:0] count, count_next;
  logic [2:0]    cand, cand_next;
  phase_t        phase, phase_next;
  logic          neg, neg_next;
  logic [31:0]   acc, acc_next;

  logic          end_msg;
  logic          digit, blank;
  logic [35:0]   prod;
  logic [31:0]   mag_neg;

  always_comb begin
    count_next = count;
    cand_next = cand;
    phase_next = phase;
    neg_next = neg;
    acc_next = acc;
    end_msg = 1'b0;
    ev = '0;
    ev.axis = AXIS_NONE;
    digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
    blank = (rx_byte == CHAR_SPACE) || ((rx_byte >= CHAR_TAB) && (rx_byte <= CHAR_CR));
    prod = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {28'b0, rx_byte - CHAR_ZERO};
    mag_neg = 32'd0;

    if (accept && rx_byte == CHAR_PIPE) begin
      end_msg = 1'b1;
    end else if (accept && rx_byte != CHAR_NL) begin
      if (count < CW'(PREFIX_LEN)) begin
        for (int k = 0; k < PREFIX_COUNT; k++) begin
          if (prefix_char(2'(k), count[2:0]) != rx_byte) begin
            cand_next[k] = 1'b0;
          end
        end
      end else if (phase != PH_DONE) begin
        if (phase == PH_SKIP && blank) begin
          phase_next = PH_SKIP;
        end else if (phase == PH_SKIP && (rx_byte == CHAR_PLUS || rx_byte == CHAR_MINUS)) begin
          neg_next = (rx_byte == CHAR_MINUS);
          phase_next = PH_DIGITS;
        end else if (digit) begin
          acc_next = (prod > MAG_CAP) ? MAG_CAP[31:0] : prod[31:0];
          phase_next = PH_DIGITS;
        end else begin
          phase_next = PH_DONE;
        end
      end
      count_next = count + CW'(1);
      if (count_next == CW'(MESSAGE_CAPACITY - 1)) begin
        end_msg = 1'b1;
      end
    end

    // result of the message that ends with this beat
    if (end_msg) begin
      ev.fire = 1'b1;
      mag_neg = 32'd0 - acc_next;
      if (neg_next) begin
        ev.value = mag_neg[15:0];
      end else if (acc_next[31]) begin
        ev.value = 16'hFFFF;
      end else begin
        ev.value = acc_next[15:0];
      end
      if (count_next >= CW'(PREFIX_LEN) && cand_next != 3'b000) begin
        if (cand_next[0]) begin
          ev.axis = AXIS_X;
        end else if (cand_next[1]) begin
          ev.axis = AXIS_Y;
        end else begin
          ev.axis = AXIS_Z;
        end
      end
      count_next = '0;
      cand_next = 3'b111;
      phase_next = PH_SKIP;
      neg_next = 1'b0;
      acc_next = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      cand <= 3'b111;
      phase <= PH_SKIP;
      neg <= 1'b0;
      acc <= 32'd0;
    end else begin
      count <= count_next;
      cand <= cand_next;
      phase <= phase_next;
      neg <= neg_next;
      acc <= acc_next;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count < CW'(MESSAGE_CAPACITY - 1))
    else $error("message count reached capacity without ending");

  a_fire_clears: assert property (@(posedge clk) disable iff (rst)
    ev.fire |=> (count == '0 && cand == 3'b111 && acc == 32'd0))
    else $error("message state not cleared after end");

  a_acc_cap: assert property (@(posedge clk) disable iff (rst)
    acc[31] |-> acc[30:0] == 31'd0)
    else $error("accumulator above saturation cap");

endmodule

// File: rtl/core/omx_mix.sv
module omx_mix import omx_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  omx_event_t         ev,
  input  logic               wheel_stall,
  output logic               wheel_valid,
  output logic signed [15:0] wheel_a,
  output logic signed [15:0] wheel_b,
  output logic signed [15:0] wheel_c,
  output logic signed [15:0] wheel_d,
  output logic [1:0]         updated_axis
);

  logic [15:0] axis_x, axis_y, axis_z;
  logic [15:0] x_next, y_next, z_next;
  logic [15:0] diff_sum;

  always_comb begin
    x_next = axis_x;
    y_next = axis_y;
    z_next = axis_z;
    case (ev.axis)
      AXIS_X: x_next = ev.value;
      AXIS_Y: y_next = ev.value;
      AXIS_Z: z_next = ev.value;
      default: begin
      end
    endcase
    diff_sum = x_next - y_next + z_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_x <= 16'd0;
      axis_y <= 16'd0;
      axis_z <= 16'd0;
      wheel_valid <= 1'b0;
    end else begin
      if (ev.fire) begin
        axis_x <= x_next;
        axis_y <= y_next;
        axis_z <= z_next;
        wheel_valid <= 1'b1;
      end else if (!wheel_stall) begin
        wheel_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev.fire) begin
      wheel_a <= diff_sum;
      wheel_b <= z_next - x_next - y_next;
      wheel_c <= diff_sum;
      wheel_d <= x_next + y_next + z_next;
      updated_axis <= ev.axis;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ev.fire |-> !(wheel_valid && wheel_stall))
    else $error("pending beat overwritten");

  a_drop_only_taken: assert property (@(posedge clk) disable iff (rst)
    $fell(wheel_valid) |-> $past(!wheel_stall))
    else $error("beat dropped while stalled");

  a_axes_hold: assert property (@(posedge clk) disable iff (rst)
    !ev.fire |=> ($stable(axis_x) && $stable(axis_y) && $stable(axis_z)))
    else $error("axis changed without message end");

endmodule

// File: rtl/core/ascii_axis_command_to_omni_wheel_mix_top.sv
// channel  | valid        | stall        | payload
// rx       | rx_valid     | rx_stall     | rx_byte
// wheel    | wheel_valid  | wheel_stall  | wheel_a..wheel_d, updated_axis
//
// one byte a cycle while rx_stall is low; a message end shows its beat on wheel in the cycle after the byte
// reset clears the message state, the three axes and wheel_valid
// rx_stall is high only while a wheel beat is held by wheel_stall
// bytes that do not end a message still wait behind a stalled wheel beat
module ascii_axis_command_to_omni_wheel_mix_top import omx_pkg::*; #(
  parameter int unsigned MESSAGE_CAPACITY = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  output logic               rx_stall,
  input  logic [7:0]         rx_byte,
  output logic               wheel_valid,
  input  logic               wheel_stall,
  output logic signed [15:0] wheel_a,
  output logic signed [15:0] wheel_b,
  output logic signed [15:0] wheel_c,
  output logic signed [15:0] wheel_d,
  output logic [1:0]         updated_axis
);

  omx_event_t ev;
  logic       accept;

  assign rx_stall = wheel_valid && wheel_stall;
  assign accept = rx_valid && !rx_stall;

  omx_parse #(
    .MESSAGE_CAPACITY(MESSAGE_CAPACITY)
  ) u_parse (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .rx_byte(rx_byte),
    .ev(ev)
  );

  omx_mix u_mix (
    .clk(clk),
    .rst(rst),
    .ev(ev),
    .wheel_stall(wheel_stall),
    .wheel_valid(wheel_valid),
    .wheel_a(wheel_a),
    .wheel_b(wheel_b),
    .wheel_c(wheel_c),
    .wheel_d(wheel_d),
    .updated_axis(updated_axis)
  );

endmodule
